>>> src/trq_pkg.sv
// Transmit retry queue: shared field widths, codes and reset values.
// No dependencies; imported by transmit_retry_queue_top.

package trq_pkg;

    localparam int TAG_W     = 16;
    localparam int TIME_W    = 32;
    localparam int ATT_W     = 5;
    localparam int LIMIT_W   = 4;
    localparam int BACKOFF_W = 16;
    localparam int OCC_W     = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [LIMIT_W-1:0]   RETRY_LIMIT_RST = 4'd3;
    localparam logic [BACKOFF_W-1:0] BACKOFF_RST     = 16'd250;

    typedef enum logic [0:0] {
        FUNC_PUSH    = 1'b0,
        FUNC_SERVICE = 1'b1
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RETRY_LIMIT = 1'b0,
        CFG_BACKOFF     = 1'b1
    } cfg_reg_t;

endpackage

>>> src/transmit_retry_queue_top.sv
// Transmit retry queue top level: ring of frame tags with retry and backoff.
// Depends on trq_pkg for widths, command codes and register reset values.
//
// Usage:
//   Command channel: an item (func, frame_tag, now_ms, send_ok) is taken at a
//   rising edge with start high and busy low. func selects push or service.
//   Result channel: done is high for exactly one cycle with push_accepted,
//   queue_full, attempted, attempt_tag, sent_done, retry_drop and occupancy.
//   The receiver cannot stall; every item gives exactly one result.
//   Config channel: cfg_valid/cfg_ready with cfg_index (0 retry_limit,
//   1 backoff_ms) and cfg_data; cfg_ready is always high. Write only while
//   no item is in flight.
// Timing:
//   An item taken at an edge passes through the input register and the
//   result register to the ports. One item per cycle is sustained: the head
//   entry state and the tag ring update in a single pass from the input
//   register to the result register, and the next item sees the new state.
// Reset:
//   rst_n clears the queue (empty, head and tail at slot 0) and loads
//   retry_limit 3 and backoff_ms 250. busy stays high until the first
//   clock edge after reset is released.

module transmit_retry_queue_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  trq_pkg::func_t                         func,
    input  logic [trq_pkg::TAG_W-1:0]              frame_tag,
    input  logic [trq_pkg::TIME_W-1:0]             now_ms,
    input  logic                                   send_ok,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [trq_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [trq_pkg::CFG_DAT_W-1:0]          cfg_data,
    output logic                                   done,
    output logic                                   push_accepted,
    output logic                                   queue_full,
    output logic                                   attempted,
    output logic [trq_pkg::TAG_W-1:0]              attempt_tag,
    output logic                                   sent_done,
    output logic                                   retry_drop,
    output logic [trq_pkg::OCC_W-1:0]              occupancy
);

    import trq_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    // configuration
    logic [LIMIT_W-1:0]   retry_limit_reg;
    logic [BACKOFF_W-1:0] backoff_reg;

    // input stage
    logic               busy_reg;
    logic               in_valid_reg;
    func_t              func_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [TIME_W-1:0]  now_reg;
    logic               ok_reg;

    // queue state
    logic [TAG_W-1:0]   tag_mem [QUEUE_DEPTH];
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ATT_W-1:0]   head_att_reg, head_att_next;
    logic [TIME_W-1:0]  head_dl_reg, head_dl_next;

    // result stage
    logic               done_reg;
    logic               push_acc_reg;
    logic               full_reg;
    logic               attempted_reg;
    logic [TAG_W-1:0]   att_tag_reg;
    logic               sent_reg;
    logic               drop_reg;

    // single pass decode
    logic               is_push;
    logic               is_full;
    logic               push_ok;
    logic               push_refused;
    logic               svc_att;
    logic [ATT_W-1:0]   att_inc;
    logic               svc_sent;
    logic               svc_drop;
    logic               svc_retry;
    logic               pop;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] nxt;
        if (idx == LAST_IDX)
        begin
            nxt = '0;
        end
        else
        begin
            nxt = idx + IDX_W'(1);
        end
        return nxt;
    endfunction

    assign busy      = busy_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg <= RETRY_LIMIT_RST;
            backoff_reg     <= BACKOFF_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RETRY_LIMIT: retry_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_BACKOFF:     backoff_reg     <= cfg_data[BACKOFF_W-1:0];
                default:         ;
            endcase
        end
    end

    // capture the item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= 1'b0;
            in_valid_reg <= start && !busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            func_reg <= func;
            tag_reg  <= frame_tag;
            now_reg  <= now_ms;
            ok_reg   <= send_ok;
        end
    end

    always_comb
    begin
        is_push      = (func_reg == FUNC_PUSH);
        is_full      = (count_reg == FULL_CNT);
        push_ok      = in_valid_reg && is_push && !is_full;
        push_refused = in_valid_reg && is_push && is_full;
        svc_att      = in_valid_reg && !is_push && (count_reg != '0) &&
                       (now_reg >= head_dl_reg);
        att_inc      = head_att_reg + ATT_W'(1);
        svc_sent     = svc_att && ok_reg;
        svc_drop     = svc_att && !ok_reg && (att_inc > ATT_W'(retry_limit_reg));
        svc_retry    = svc_att && !ok_reg && !svc_drop;
        pop          = svc_sent || svc_drop;

        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        head_att_next = head_att_reg;
        head_dl_next  = head_dl_reg;

        if (push_ok)
        begin
            tail_next  = next_slot(tail_reg);
            count_next = count_reg + CNT_W'(1);
        end

        if (pop)
        begin
            head_next     = next_slot(head_reg);
            count_next    = count_reg - CNT_W'(1);
            head_att_next = '0;
            head_dl_next  = '0;
        end
        else if (svc_retry)
        begin
            head_att_next = att_inc;
            head_dl_next  = now_reg + TIME_W'(backoff_reg);
        end
    end

    // advance queue state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            head_att_reg <= '0;
            head_dl_reg  <= '0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            head_att_reg <= head_att_next;
            head_dl_reg  <= head_dl_next;
        end
    end

    // tag ring: write at tail, read at head
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            tag_mem[tail_reg] <= tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            att_tag_reg <= tag_mem[head_reg];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            push_acc_reg  <= push_ok;
            full_reg      <= push_refused;
            attempted_reg <= svc_att;
            sent_reg      <= svc_sent;
            drop_reg      <= svc_drop;
        end
    end

    assign done          = done_reg;
    assign push_accepted = push_acc_reg;
    assign queue_full    = full_reg;
    assign attempted     = attempted_reg;
    assign attempt_tag   = attempted_reg ? att_tag_reg : '0;
    assign sent_done     = sent_reg;
    assign retry_drop    = drop_reg;
    assign occupancy     = OCC_W'(count_reg);

`ifndef ASSERT_OFF
    a_result_follows_item: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_valid_reg |=> done_reg
    ) else $error("item in input stage gave no result");

    a_count_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT
    ) else $error("entry count exceeds queue depth");

    a_empty_aligned: assert property (
        @(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg)
    ) else $error("empty queue with head and tail apart");

    a_flags_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n)
        done_reg |-> $onehot0({push_acc_reg, full_reg, attempted_reg})
    ) else $error("more than one outcome flag set");

    a_pop_needs_attempt: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done_reg && (sent_reg || drop_reg)) |-> (attempted_reg && !(sent_reg && drop_reg))
    ) else $error("pop without a single attempt outcome");

    a_push_counts: assert property (
        @(posedge clk) disable iff (!rst_n)
        push_ok |=> (count_reg == $past(count_reg) + CNT_W'(1))
    ) else $error("accepted push did not raise the count");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for transmit_retry_queue_top: push/service items against a
// cycle-free prediction of the ring queue, retry counts and backoff deadlines.
// Depends on trq_pkg and the transmit_retry_queue_top RTL only.

module testbench;
    import trq_pkg::*;

    localparam int QUEUE_DEPTH = 4;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic               push_accepted;
        logic               queue_full;
        logic               attempted;
        logic [TAG_W-1:0]   attempt_tag;
        logic               sent_done;
        logic               retry_drop;
        logic [OCC_W-1:0]   occupancy;
    } outcome_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    func_t                func = FUNC_PUSH;
    logic [TAG_W-1:0]     frame_tag = '0;
    logic [TIME_W-1:0]    now_ms = '0;
    logic                 send_ok = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cfg_reg_t             cfg_index = CFG_RETRY_LIMIT;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic                 done;
    logic                 push_accepted;
    logic                 queue_full;
    logic                 attempted;
    logic [TAG_W-1:0]     attempt_tag;
    logic                 sent_done;
    logic                 retry_drop;
    logic [OCC_W-1:0]     occupancy;

    // predicted queue contents and registers
    logic [TAG_W-1:0]     slot_tag      [QUEUE_DEPTH];
    logic [ATT_W-1:0]     slot_tries    [QUEUE_DEPTH];
    logic [TIME_W-1:0]    slot_deadline [QUEUE_DEPTH];
    int unsigned          head_slot = 0;
    int unsigned          tail_slot = 0;
    int unsigned          fill_count = 0;
    logic [LIMIT_W-1:0]   limit_reg = RETRY_LIMIT_RST;
    logic [BACKOFF_W-1:0] backoff_reg = BACKOFF_RST;

    outcome_t             expected_outcomes[$];
    logic [TIME_W-1:0]    clock_ms = '0;
    int                   mismatches = 0;
    int                   items_sent = 0;
    int                   tags_stored = 0;
    int                   pushes_refused = 0;
    int                   sends_ok = 0;
    int                   sends_failed = 0;
    int                   entries_dropped = 0;
    int                   services_idle = 0;
    int                   reg_writes = 0;
    int                   cycle_count = 0;

    transmit_retry_queue_top #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .frame_tag     (frame_tag),
        .now_ms        (now_ms),
        .send_ok       (send_ok),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .push_accepted (push_accepted),
        .queue_full    (queue_full),
        .attempted     (attempted),
        .attempt_tag   (attempt_tag),
        .sent_done     (sent_done),
        .retry_drop    (retry_drop),
        .occupancy     (occupancy)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("transmit_retry_queue_top regression: fail");
        $finish;
    end

    function automatic outcome_t step_queue(input func_t f, input logic [TAG_W-1:0] tag,
                                            input logic [TIME_W-1:0] now, input logic ok);
        outcome_t r;
        int unsigned h;
        r = '{default: '0};
        h = head_slot;
        if (f == FUNC_PUSH)
        begin
            if (fill_count >= QUEUE_DEPTH)
            begin
                r.queue_full = 1'b1;
                pushes_refused++;
            end
            else
            begin
                slot_tag[tail_slot]      = tag;
                slot_tries[tail_slot]    = '0;
                slot_deadline[tail_slot] = '0;
                tail_slot  = (tail_slot + 1) % QUEUE_DEPTH;
                fill_count++;
                r.push_accepted = 1'b1;
                tags_stored++;
            end
        end
        else if (fill_count != 0 && now >= slot_deadline[h])
        begin
            r.attempted   = 1'b1;
            r.attempt_tag = slot_tag[h];
            if (ok)
            begin
                r.sent_done = 1'b1;
                sends_ok++;
            end
            else
            begin
                sends_failed++;
                slot_tries[h] = slot_tries[h] + ATT_W'(1);
                if (slot_tries[h] > limit_reg)
                begin
                    r.retry_drop = 1'b1;
                    entries_dropped++;
                end
                else
                    slot_deadline[h] = now + TIME_W'(backoff_reg);
            end
            if (r.sent_done || r.retry_drop)
            begin
                head_slot = (h + 1) % QUEUE_DEPTH;
                fill_count--;
            end
        end
        else
            services_idle++;
        r.occupancy = OCC_W'(fill_count);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        outcome_t exp_r;
        if (rst_n && done)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $error("result with no item pending");
                mismatches++;
            end
            else
            begin
                exp_r = expected_outcomes.pop_front();
                check_field("push_accepted", 32'(exp_r.push_accepted), 32'(push_accepted));
                check_field("queue_full", 32'(exp_r.queue_full), 32'(queue_full));
                check_field("attempted", 32'(exp_r.attempted), 32'(attempted));
                check_field("attempt_tag", 32'(exp_r.attempt_tag), 32'(attempt_tag));
                check_field("sent_done", 32'(exp_r.sent_done), 32'(sent_done));
                check_field("retry_drop", 32'(exp_r.retry_drop), 32'(retry_drop));
                check_field("occupancy", 32'(exp_r.occupancy), 32'(occupancy));
            end
        end
    end

    task automatic issue_item(input func_t f, input logic [TAG_W-1:0] tag,
                              input logic [TIME_W-1:0] now, input logic ok);
        start     <= 1'b1;
        func      <= f;
        frame_tag <= tag;
        now_ms    <= now;
        send_ok   <= ok;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_outcomes.push_back(step_queue(f, tag, now, ok));
        items_sent++;
    endtask

    task automatic idle_gap(input int pct);
        while ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // hold off until every result is back, then let the pipeline settle
    task automatic wait_drained;
        start <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_RETRY_LIMIT)
            limit_reg = data[LIMIT_W-1:0];
        else
            backoff_reg = data[BACKOFF_W-1:0];
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_item(input int ok_pct);
        func_t             f;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] now;
        logic              ok;
        int                push_pct;
        f   = FUNC_SERVICE;
        tag = TAG_W'($urandom);
        now = $urandom;
        ok  = ($urandom_range(99) < ok_pct);
        if ($urandom_range(99) < 5)
            f = func_t'($urandom_range(1));
        else
        begin
            push_pct = (fill_count == 0) ? 70 : (fill_count >= QUEUE_DEPTH) ? 15 : 45;
            if ($urandom_range(99) < push_pct)
                f = FUNC_PUSH;
            else
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3: clock_ms = clock_ms + $urandom_range(3);
                    4, 5:       if (fill_count != 0) clock_ms = slot_deadline[head_slot];
                    6:          if (fill_count != 0) clock_ms = slot_deadline[head_slot] - 1;
                    7:          clock_ms = clock_ms + backoff_reg + $urandom_range(2);
                    8:          clock_ms = $urandom;
                    default:    clock_ms = 32'hFFFF_FFFF - $urandom_range(backoff_reg);
                endcase
                now = clock_ms;
            end
        end
        issue_item(f, tag, now, ok);
    endtask

    task automatic run_traffic(input logic [LIMIT_W-1:0] limit, input logic [BACKOFF_W-1:0] bk,
                               input int idle_pct, input int ok_pct, input int count);
        wait_drained();
        write_reg(CFG_RETRY_LIMIT, {(CFG_DAT_W-LIMIT_W)'($urandom), limit});
        write_reg(CFG_BACKOFF, bk);
        for (int n = 0; n < count; n++)
        begin
            idle_gap(idle_pct);
            random_item(ok_pct);
            if ($urandom_range(149) == 0)
                wait_drained();
        end
    endtask

    task automatic test_ring_and_retries;
        issue_item(FUNC_SERVICE, 16'h1111, 32'hFFFF_FFFF, 1'b1);
        issue_item(FUNC_PUSH, 16'h0000, 32'h0, 1'b0);
        issue_item(FUNC_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        issue_item(FUNC_PUSH, 16'hA5A5, 32'h5555_5555, 1'b0);
        issue_item(FUNC_PUSH, 16'h5A5A, 32'hAAAA_AAAA, 1'b1);
        issue_item(FUNC_PUSH, 16'h1234, 32'h0, 1'b0);
        issue_item(FUNC_SERVICE, 16'hFFFF, 32'd0, 1'b0);
        issue_item(FUNC_SERVICE, 16'h0, 32'd249, 1'b1);
        issue_item(FUNC_SERVICE, 16'h0, 32'd250, 1'b0);
        issue_item(FUNC_SERVICE, 16'h0, 32'd500, 1'b0);
        issue_item(FUNC_SERVICE, 16'h0, 32'hFFFF_FFFF, 1'b0);
        issue_item(FUNC_SERVICE, 16'h0, 32'd0, 1'b1);
        issue_item(FUNC_PUSH, 16'h8001, 32'h0, 1'b0);
        issue_item(FUNC_PUSH, 16'h7FFE, 32'h0, 1'b0);
        issue_item(FUNC_SERVICE, 16'h0, 32'd0, 1'b1);
    endtask

    task automatic test_limits_and_wrap;
        wait_drained();
        write_reg(CFG_RETRY_LIMIT, 16'hFFF0);
        write_reg(CFG_BACKOFF, 16'hFFFF);
        issue_item(FUNC_SERVICE, 16'h0, 32'hFFFF_FFF0, 1'b0);
        wait_drained();
        write_reg(CFG_RETRY_LIMIT, 16'h000F);
        issue_item(FUNC_SERVICE, 16'h0, 32'hFFFF_FFF0, 1'b0);
        issue_item(FUNC_SERVICE, 16'h0, 32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_random_traffic;
        run_traffic(4'd3, 16'd250, 0, 50, 200);
        run_traffic(4'd0, 16'd0, 82, 30, 200);
        run_traffic(4'd15, 16'hFFFF, 33, 20, 200);
        run_traffic(4'd15, 16'd0, 0, 10, 200);
        run_traffic(LIMIT_W'($urandom), BACKOFF_W'($urandom), 82, 40, 200);
        run_traffic(4'd1, 16'd1, 33, 35, 200);
        run_traffic(LIMIT_W'($urandom), BACKOFF_W'($urandom_range(15)), 0, 30, 200);
        run_traffic(LIMIT_W'($urandom), BACKOFF_W'($urandom), 82, 25, 200);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_ring_and_retries();
        test_limits_and_wrap();
        test_random_traffic();
        wait_drained();
        $display("covered %0d items over %0d register writes: %0d tags stored, %0d refused full",
                 items_sent, reg_writes, tags_stored, pushes_refused);
        $display("services: %0d sent, %0d failed, %0d dropped, %0d with nothing due",
                 sends_ok, sends_failed, entries_dropped, services_idle);
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("transmit_retry_queue_top regression: pass");
        else
            $display("transmit_retry_queue_top regression: fail");
        $finish;
    end

endmodule
